[rtl/core/ipc_pkg.sv]
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, codes and helpers of the interrupt priority controller.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int SRC_W  = 5;
    localparam int VAL_W  = 8;
    localparam int PRIO_W = 8;
    localparam int KIND_W = 3;
    localparam int MODE_W = 3;

    localparam logic [PRIO_W-1:0] PRIO_RESET = 8'hFF;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [MODE_W-1:0] mode_t;

    localparam kind_t KIND_SET_MODE = 3'd0;
    localparam kind_t KIND_LINE     = 3'd1;
    localparam kind_t KIND_SW_PEND  = 3'd2;
    localparam kind_t KIND_READ_TOP = 3'd3;
    localparam kind_t KIND_CLAIM    = 3'd4;
    localparam kind_t KIND_ENABLE   = 3'd5;
    localparam kind_t KIND_PRIO     = 3'd6;

    localparam mode_t MODE_INACTIVE   = 3'd0;
    localparam mode_t MODE_DETACHED   = 3'd1;
    localparam mode_t MODE_EDGE_RISE  = 3'd2;
    localparam mode_t MODE_EDGE_FALL  = 3'd3;
    localparam mode_t MODE_LEVEL_HIGH = 3'd4;
    localparam mode_t MODE_LEVEL_LOW  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_CLAIM,
        ST_DONE
    } state_t;

    // write strobes and data for one source entry
    typedef struct packed {
        logic              we_mode;
        mode_t             mode;
        logic              we_pend;
        logic              pend;
        logic              we_en;
        logic              en;
        logic              we_prio;
        logic [PRIO_W-1:0] prio;
        logic              we_line;
        logic              line;
    } tbl_wr_t;

    // contents of one source entry
    typedef struct packed {
        mode_t             mode;
        logic              pend;
        logic              en;
        logic              line;
        logic [PRIO_W-1:0] prio;
    } tbl_rd_t;

    // control of the shared best-candidate compare unit
    typedef struct packed {
        logic clear;
        logic step;
    } best_ctl_t;

    // level modes follow the line, all others keep the given bit
    function automatic logic mirror_or(mode_t mode, logic line, logic keep);
        logic r;
        r = keep;
        if (mode == MODE_LEVEL_HIGH) begin
            r = line;
        end else if (mode == MODE_LEVEL_LOW) begin
            r = ~line;
        end
        return r;
    endfunction

endpackage

[rtl/core/interrupt_priority_controller_unit.sv]
// ----------------------------------------------------------------------------
// interrupt_priority_controller_unit
// Interrupt domain with per-source mode, line, pending, enable and priority;
// read top and claim scan the sources for the lowest priority winner.
// ----------------------------------------------------------------------------
// sequence: register accesses pass EXEC and DONE from accept to result beat;
//   read top passes SCAN and DONE, claim SCAN, CLAIM and DONE; the scan
//   checks one source per cycle in the compare unit, from source 1 upward
// throughput: one access at a time, the next beat is taken once the
//   result sits in the output register
// reset: synchronous active low, source state and threshold take their reset values
module interrupt_priority_controller_unit
    import ipc_pkg::*;
#(
    parameter int NUM_SOURCES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,  // priority_threshold
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,      // source[4:0], value[12:5], zero[15:13]
    input  logic [2:0]  s_tuser,      // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata       // top_source[4:0], top_priority[12:5], zero[15:13]
);

    // only the addressable sources need storage
    localparam int DEPTH = (NUM_SOURCES < (1 << SRC_W)) ? NUM_SOURCES : (1 << SRC_W);
    localparam int AW    = $clog2(DEPTH);

    logic [PRIO_W-1:0] threshold_reg;
    logic [AW-1:0]     addr;
    tbl_wr_t           wr;
    tbl_rd_t           rd;
    best_ctl_t         best_ctl;
    logic              found;
    logic [AW-1:0]     best_id;
    logic [PRIO_W-1:0] best_prio;
    logic [SRC_W-1:0]  top_source;
    logic [PRIO_W-1:0] top_priority;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
        end else if (cfg_wr_en) begin
            threshold_reg <= cfg_wr_data;
        end
    end

    ipc_ctrl #(
        .NUM_SOURCES (NUM_SOURCES),
        .DEPTH       (DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_kind          (s_tuser),
        .in_source        (s_tdata[4:0]),
        .in_value         (s_tdata[12:5]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_top_source   (top_source),
        .out_top_priority (top_priority),
        .addr             (addr),
        .wr               (wr),
        .rd               (rd),
        .best_ctl         (best_ctl),
        .found            (found),
        .best_id          (best_id),
        .best_prio        (best_prio)
    );

    ipc_src_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .addr    (addr),
        .wr      (wr),
        .rd      (rd)
    );

    ipc_best_unit #(
        .AW (AW)
    ) u_best (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (best_ctl),
        .id        (addr),
        .rd        (rd),
        .threshold (threshold_reg),
        .found     (found),
        .best_id   (best_id),
        .best_prio (best_prio)
    );

    assign m_tdata = {3'b000, top_priority, top_source};

endmodule

[rtl/core/ipc_src_table.sv]
// ----------------------------------------------------------------------------
// ipc_src_table
// Per-source state: mode, pending, enable, priority and line level, with
// one shared address for read and write.
// ----------------------------------------------------------------------------
module ipc_src_table
    import ipc_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [AW-1:0] addr,
    input  tbl_wr_t       wr,
    output tbl_rd_t       rd
);

    mode_t             mode_reg [DEPTH];
    logic              pend_reg [DEPTH];
    logic              en_reg   [DEPTH];
    logic [PRIO_W-1:0] prio_reg [DEPTH];
    logic              line_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                mode_reg[i] <= MODE_INACTIVE;
                pend_reg[i] <= 1'b0;
                en_reg[i]   <= 1'b0;
                prio_reg[i] <= PRIO_RESET;
                line_reg[i] <= 1'b0;
            end
        end else begin
            if (wr.we_mode) mode_reg[addr] <= wr.mode;
            if (wr.we_pend) pend_reg[addr] <= wr.pend;
            if (wr.we_en)   en_reg[addr]   <= wr.en;
            if (wr.we_prio) prio_reg[addr] <= wr.prio;
            if (wr.we_line) line_reg[addr] <= wr.line;
        end
    end

    // addresses past the last entry read as a cleared entry
    always_comb begin
        rd = '0;
        if (32'(addr) < DEPTH) begin
            rd.mode = mode_reg[addr];
            rd.pend = pend_reg[addr];
            rd.en   = en_reg[addr];
            rd.line = line_reg[addr];
            rd.prio = prio_reg[addr];
        end
    end

endmodule

[rtl/core/ipc_best_unit.sv]
// ----------------------------------------------------------------------------
// ipc_best_unit
// Shared compare unit: while stepping, checks one entry per cycle against the
// threshold and keeps the best candidate seen so far.
// ----------------------------------------------------------------------------
module ipc_best_unit
    import ipc_pkg::*;
#(
    parameter int AW = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  best_ctl_t         ctl,
    input  logic [AW-1:0]     id,
    input  tbl_rd_t           rd,
    input  logic [PRIO_W-1:0] threshold,
    output logic              found,
    output logic [AW-1:0]     best_id,
    output logic [PRIO_W-1:0] best_prio
);

    logic              found_reg;
    logic [AW-1:0]     id_reg;
    logic [PRIO_W-1:0] prio_reg;
    logic              cand;
    logic              better;

    assign cand   = ctl.step && rd.pend && rd.en &&
                    ((threshold == '0) || (rd.prio < threshold));
    // strict compare keeps the lower id on a tie
    assign better = !found_reg || (rd.prio < prio_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (cand && better) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clear && cand && better) begin
            id_reg   <= id;
            prio_reg <= rd.prio;
        end
    end

    assign found     = found_reg;
    assign best_id   = id_reg;
    assign best_prio = prio_reg;

endmodule

[rtl/core/ipc_ctrl.sv]
// ----------------------------------------------------------------------------
// ipc_ctrl
// Access sequencer: takes one beat, applies it to the source table or
// scans sources 1 to DEPTH-1, then loads the result into the output register.
// ----------------------------------------------------------------------------
module ipc_ctrl
    import ipc_pkg::*;
#(
    parameter int NUM_SOURCES = 32,
    parameter int DEPTH       = 32,
    parameter int AW          = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  kind_t             in_kind,
    input  logic [SRC_W-1:0]  in_source,
    input  logic [VAL_W-1:0]  in_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SRC_W-1:0]  out_top_source,
    output logic [PRIO_W-1:0] out_top_priority,
    output logic [AW-1:0]     addr,
    output tbl_wr_t           wr,
    input  tbl_rd_t           rd,
    output best_ctl_t         best_ctl,
    input  logic              found,
    input  logic [AW-1:0]     best_id,
    input  logic [PRIO_W-1:0] best_prio
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    state_t            state_reg, state_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    kind_t             kind_reg;
    logic [SRC_W-1:0]  src_reg;
    logic [VAL_W-1:0]  val_reg;
    logic              out_valid_reg;
    logic [SRC_W-1:0]  out_src_reg;
    logic [PRIO_W-1:0] out_prio_reg;

    logic accept;
    logic scan_kind;
    logic src_ok;
    logic bit_v;
    logic out_load;

    assign accept    = in_ready && in_valid;
    assign scan_kind = (kind_reg == KIND_READ_TOP) || (kind_reg == KIND_CLAIM);
    assign src_ok    = 32'(src_reg) < NUM_SOURCES;
    assign bit_v     = val_reg[0];
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= in_kind;
            src_reg  <= in_source;
            val_reg  <= in_value;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cnt_next = AW'(1);
                    if ((in_kind == KIND_READ_TOP) || (in_kind == KIND_CLAIM)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC: begin
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX) begin
                    state_next = (kind_reg == KIND_CLAIM) ? ST_CLAIM : ST_DONE;
                end
            end
            ST_CLAIM: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        in_ready       = 1'b0;
        addr           = cnt_reg;
        wr             = '0;
        best_ctl.clear = 1'b0;
        best_ctl.step  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready       = 1'b1;
                best_ctl.clear = in_valid;
            end
            ST_EXEC: begin
                addr = src_reg[AW-1:0];
                if (src_ok) begin
                    case (kind_reg)
                        KIND_SET_MODE: begin
                            if (val_reg <= VAL_W'(MODE_LEVEL_LOW)) begin
                                wr.we_mode = 1'b1;
                                wr.mode    = val_reg[MODE_W-1:0];
                                if (val_reg == VAL_W'(MODE_INACTIVE)) begin
                                    wr.we_pend = 1'b1;
                                    wr.pend    = 1'b0;
                                end
                            end
                        end
                        KIND_LINE: begin
                            wr.we_line = 1'b1;
                            wr.line    = bit_v;
                            wr.pend    = 1'b1;
                            if (rd.mode == MODE_EDGE_RISE) begin
                                wr.we_pend = !rd.line && bit_v;
                            end else if (rd.mode == MODE_EDGE_FALL) begin
                                wr.we_pend = rd.line && !bit_v;
                            end else begin
                                wr.we_pend = 1'b1;
                                wr.pend    = mirror_or(rd.mode, bit_v, rd.pend);
                            end
                        end
                        KIND_SW_PEND: begin
                            if (rd.mode != MODE_INACTIVE) begin
                                wr.we_pend = 1'b1;
                                wr.pend    = mirror_or(rd.mode, rd.line, bit_v);
                            end
                        end
                        KIND_ENABLE: begin
                            wr.we_en = 1'b1;
                            wr.en    = bit_v;
                        end
                        KIND_PRIO: begin
                            wr.we_prio = 1'b1;
                            wr.prio    = val_reg;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                addr          = cnt_reg;
                best_ctl.step = 1'b1;
            end
            ST_CLAIM: begin
                addr = best_id;
                // clear the winner, a level source still asserted stays pending
                if (found) begin
                    wr.we_pend = 1'b1;
                    wr.pend    = mirror_or(rd.mode, rd.line, 1'b0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_src_reg  <= (scan_kind && found) ? SRC_W'(best_id) : '0;
            out_prio_reg <= (scan_kind && found) ? best_prio : '0;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_top_source   = out_src_reg;
    assign out_top_priority = out_prio_reg;

endmodule

[rtl/core/ipc_checker.sv]
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the interrupt priority controller, bound to the top.
// ----------------------------------------------------------------------------
module ipc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one access at a time: busy right after a beat is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an access is in progress");

    // no winner means no priority
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[4:0] == 5'd0) |-> (m_tdata[12:5] == 8'd0))
        else $error("priority reported without a winner");

    // padding bits stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:13] == 3'd0))
        else $error("nonzero padding in result beat");

endmodule

bind interrupt_priority_controller_unit ipc_checker u_ipc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
